// ===== design/chacha_pkg.sv =====
// Package for the ChaCha keystream engine: constants, channel types, helpers.
// No dependencies; used by the front, queue, back and top-level design files.
package chacha_pkg;

  localparam logic [31:0] CONST_W0 = 32'h61707865;
  localparam logic [31:0] CONST_W1 = 32'h3320646e;
  localparam logic [31:0] CONST_W2 = 32'h79622d32;
  localparam logic [31:0] CONST_W3 = 32'h6b206574;

  localparam logic [2:0] REG_KEY01   = 3'd0;
  localparam logic [2:0] REG_KEY23   = 3'd1;
  localparam logic [2:0] REG_KEY45   = 3'd2;
  localparam logic [2:0] REG_KEY67   = 3'd3;
  localparam logic [2:0] REG_NONCE01 = 3'd4;
  localparam logic [2:0] REG_NONCE2  = 3'd5;
  localparam logic [2:0] REG_CTR     = 3'd6;
  localparam logic [2:0] REG_ROUNDS  = 3'd7;

  // One classified item as it travels from the front part to the back part.
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;     // already saturated to 8
    logic        xor_mode;
    logic        new_block; // make a fresh block before using a word
  } item_t;

  typedef logic [15:0][31:0] state_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [127:0] qr(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] c, input logic [31:0] d);
    logic [31:0] a1, b1, c1, d1;
    a1 = a + b;   d1 = rotl(d ^ a1, 16);
    c1 = c + d1;  b1 = rotl(b ^ c1, 12);
    a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
    c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
    qr = {d1, c1, b1, a1};
  endfunction

endpackage

// ===== design/chacha_front.sv =====
// Front part: takes input transactions, saturates the count and decides which
// items start a new block. Depends on chacha_pkg.
module chacha_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [63:0]        data_bytes,
  input  logic [3:0]         byte_count,
  input  logic               xor_mode,
  input  logic               first_of_message,
  output logic               q_valid,
  input  logic               q_ready,
  output chacha_pkg::item_t  q_item
);

  // Words already used in the current block as seen by the front; mirrors the back.
  logic [2:0] pos_r, pos_nxt;
  logic       ready_r, ready_nxt;
  logic       acc;
  logic       mk;

  assign in_tready = q_ready;
  assign q_valid   = in_tvalid;
  assign acc       = in_tvalid && q_ready;
  assign mk        = first_of_message || !ready_r;

  always_comb begin
    q_item.data      = data_bytes;
    q_item.count     = (byte_count > 4'd8) ? 4'd8 : byte_count;
    q_item.xor_mode  = xor_mode;
    q_item.new_block = mk;
    pos_nxt   = pos_r;
    ready_nxt = ready_r;
    if (acc) begin
      if (mk) pos_nxt = 3'd0;
      if ((mk ? 3'd0 : pos_r) == 3'd7) begin
        pos_nxt   = 3'd0;
        ready_nxt = 1'b0;
      end else begin
        pos_nxt   = (mk ? 3'd0 : pos_r) + 3'd1;
        ready_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 3'd0;
      ready_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      ready_r <= ready_nxt;
    end
  end

endmodule

// ===== design/chacha_queue.sv =====
// Two-entry queue between front and back parts. Depends on chacha_pkg.
module chacha_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  chacha_pkg::item_t wr_item,
  output logic              rd_valid,
  input  logic              rd_ready,
  output chacha_pkg::item_t rd_item
);

  chacha_pkg::item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_item  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== design/chacha_back.sv =====
// Back part: runs the double rounds (one per cycle), holds the keystream
// block, applies it and drives the output register. Depends on chacha_pkg.
module chacha_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  chacha_pkg::item_t q_item,
  input  logic [255:0]      key,
  input  logic [95:0]       nonce,
  input  logic [7:0]        num_rounds,
  input  logic              ctr_load,
  input  logic [31:0]       ctr_value,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       result_bytes,
  output logic [3:0]        result_count
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_ADD  = 2'd2;

  logic [1:0]                st_r;
  logic [7:0]                dr_r;
  chacha_pkg::state_t        w_r, init_r, dr_out;
  logic [7:0][63:0]          ks_r;
  logic [2:0]                pos_r;
  logic [31:0]               ctr_r;
  logic                      ov_r;
  logic [63:0]               ob_r;
  logic [3:0]                oc_r;
  logic                      out_free;
  logic                      use_word;
  logic [63:0]               ks_w, res, mask;
  chacha_pkg::state_t        init_v;

  assign out_free     = !ov_r || out_tready;
  assign out_tvalid   = ov_r;
  assign result_bytes = ob_r;
  assign result_count = oc_r;

  always_comb begin
    init_v[0] = chacha_pkg::CONST_W0;
    init_v[1] = chacha_pkg::CONST_W1;
    init_v[2] = chacha_pkg::CONST_W2;
    init_v[3] = chacha_pkg::CONST_W3;
    for (int i = 0; i < 8; i++) init_v[4 + i] = key[32 * i +: 32];
    init_v[12] = ctr_r;
    init_v[13] = nonce[31:0];
    init_v[14] = nonce[63:32];
    init_v[15] = nonce[95:64];
  end

  // One double round: column quarter rounds, then diagonal ones.
  always_comb begin
    chacha_pkg::state_t c;
    c = w_r;
    for (int i = 0; i < 4; i++)
      {c[12 + i], c[8 + i], c[4 + i], c[i]} =
        chacha_pkg::qr(c[i], c[4 + i], c[8 + i], c[12 + i]);
    for (int i = 0; i < 4; i++)
      {c[12 + (i + 3) % 4], c[8 + (i + 2) % 4], c[4 + (i + 1) % 4], c[i]} =
        chacha_pkg::qr(c[i], c[4 + (i + 1) % 4], c[8 + (i + 2) % 4],
                       c[12 + (i + 3) % 4]);
    dr_out = c;
  end

  assign use_word = (st_r == S_IDLE) && q_valid && !q_item.new_block && out_free;
  assign q_ready  = use_word;
  assign ks_w     = ks_r[pos_r];

  always_comb begin
    res  = q_item.xor_mode ? (q_item.data ^ ks_w) : ks_w;
    mask = '0;
    for (int i = 0; i < 8; i++)
      if (4'(i) < q_item.count) mask[8 * i +: 8] = 8'hff;
    res = res & mask;
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && q_valid && q_item.new_block) begin
      w_r    <= init_v;
      init_r <= init_v;
      dr_r   <= 8'((9'(num_rounds) + 9'd1) >> 1);
    end else if (st_r == S_RUN && dr_r != 8'd0) begin
      w_r  <= dr_out;
      dr_r <= dr_r - 8'd1;
    end
    if (st_r == S_ADD)
      for (int i = 0; i < 8; i++)
        ks_r[i] <= {w_r[2 * i + 1] + init_r[2 * i + 1], w_r[2 * i] + init_r[2 * i]};
    if (use_word) begin
      ob_r <= res;
      oc_r <= q_item.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      pos_r <= 3'd0;
      ctr_r <= 32'd1;
      ov_r  <= 1'b0;
    end else begin
      if (ctr_load) ctr_r <= ctr_value;
      if (out_tready) ov_r <= 1'b0;
      if (use_word) begin
        ov_r  <= 1'b1;
        pos_r <= pos_r + 3'd1;
      end
      unique case (st_r)
        S_IDLE: if (q_valid && q_item.new_block) begin
          st_r  <= S_RUN;
          ctr_r <= ctr_r + 32'd1;
        end
        S_RUN: if (dr_r == 8'd0) st_r <= S_ADD;
        S_ADD: begin
          st_r  <= S_IDLE;
          pos_r <= 3'd0;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // The queued item that asked for the block is then taken as an ordinary one.
  // Its new_block flag is cleared by the top through the queue read path.

endmodule

// ===== design/chacha_stream_cipher.sv =====
// ChaCha keystream engine, top level. Holds the configuration registers and
// wires front, queue and back parts. Depends on chacha_pkg and all submodules.
//
// Each input transaction consumes one 64-bit keystream word (RFC 8439 state
// layout) and yields one output transaction with data XOR keystream or raw
// keystream, bytes at and above the count zeroed. An item that starts a new
// message, or arrives when the current 64-byte block is used up, first makes
// a block (load, one double round per cycle in the round unit, end check and
// final addition) and is then taken for its own word. The other seven items
// of a block are taken back to back from the stored block while items are
// queued and the output is not stalled. A two-entry queue lets the input side
// run ahead while a block is made; the output register lets a new item be
// taken as a waiting result leaves. Configure only while idle.
module chacha_stream_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // data_bytes[63:0], byte_count[67:64], xor_mode[68], zero
  input  logic        in_tuser,   // first_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // result_bytes[63:0], result_count[67:64], zero
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [255:0]      key_r;
  logic [95:0]       nonce_r;
  logic [7:0]        rounds_r;
  logic              fq_valid, fq_ready, qb_valid, qb_ready;
  chacha_pkg::item_t fq_item, qb_item, qb_item_m;
  logic              mk_pend_r;
  logic [63:0]       rb;
  logic [3:0]        rc;

  // Hold the key, nonce and round count; the counter lives in the back part.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= '0;
      nonce_r  <= '0;
      rounds_r <= 8'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        chacha_pkg::REG_KEY01:   key_r[63:0]    <= cfg_wdata;
        chacha_pkg::REG_KEY23:   key_r[127:64]  <= cfg_wdata;
        chacha_pkg::REG_KEY45:   key_r[191:128] <= cfg_wdata;
        chacha_pkg::REG_KEY67:   key_r[255:192] <= cfg_wdata;
        chacha_pkg::REG_NONCE01: nonce_r[63:0]  <= cfg_wdata;
        chacha_pkg::REG_NONCE2:  nonce_r[95:64] <= cfg_wdata[31:0];
        chacha_pkg::REG_CTR:     ;
        chacha_pkg::REG_ROUNDS:  rounds_r       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  chacha_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .data_bytes(in_tdata[63:0]), .byte_count(in_tdata[67:64]),
    .xor_mode(in_tdata[68]), .first_of_message(in_tuser),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
  );

  chacha_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(fq_item),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_item(qb_item)
  );

  // Drop the head item's block request once the back part has started it.
  // The back part is always idle when a new head asks for a block.
  always_ff @(posedge clk) begin
    if (!rst_n) mk_pend_r <= 1'b0;
    else if (qb_valid && qb_ready) mk_pend_r <= 1'b0;
    else if (qb_valid && qb_item.new_block && !mk_pend_r)
      mk_pend_r <= 1'b1;
  end

  always_comb begin
    qb_item_m = qb_item;
    if (mk_pend_r) qb_item_m.new_block = 1'b0;
  end

  chacha_back u_back (
    .clk, .rst_n, .q_valid(qb_valid), .q_ready(qb_ready), .q_item(qb_item_m),
    .key(key_r), .nonce(nonce_r), .num_rounds(rounds_r),
    .ctr_load(cfg_we && cfg_index == chacha_pkg::REG_CTR),
    .ctr_value(cfg_wdata[31:0]),
    .out_tvalid, .out_tready, .result_bytes(rb), .result_count(rc)
  );

  assign out_tdata = {4'd0, rc, rb};

endmodule

// ===== design/chacha_stream_cipher_chk.sv =====
// Port-level checker for the ChaCha keystream engine, bound to the top level.
// Depends on chacha_stream_cipher port names only.
module chacha_stream_cipher_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[67:64] <= 4'd8 && out_tdata[71:68] == 4'd0)
    else $error("bad result count");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[67:64] == 4'd0 |-> out_tdata[63:0] == 64'd0)
    else $error("empty result carries bytes");

endmodule

bind chacha_stream_cipher chacha_stream_cipher_chk u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);
